// ----- rtl/lpht_pkg.sv -----
// Shared types and constants for the linear-probe hash table.
package lpht_pkg;

	// Width of the reported slot location
	localparam int unsigned LOC_W = 5;

	// Operation codes carried in s_tuser
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_RESP
	} state_t;

endpackage

// ----- rtl/lpht_hash.sv -----
// Home-slot unit: key modulo TABLE_SIZE by reciprocal multiplication, one key byte at a time.
module lpht_hash #(
	parameter int unsigned TABLE_SIZE = 32,
	parameter int unsigned KEY_BITS   = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [KEY_BITS-1:0]           key,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] home
);
	localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
	localparam int unsigned DIG_W  = 8;
	localparam int unsigned N_DIG  = (KEY_BITS + DIG_W - 1) / DIG_W;
	localparam int unsigned PAD_W  = N_DIG * DIG_W;
	localparam int unsigned VAL_W  = IDX_W + DIG_W;
	localparam int unsigned SHIFT  = VAL_W + IDX_W;
	localparam int unsigned RCP_W  = VAL_W + 2;
	localparam int unsigned PROD_W = VAL_W + RCP_W;
	localparam int unsigned STEP_W = $clog2(N_DIG + 1);
	localparam longint unsigned RCP =
		((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
	localparam logic [RCP_W-1:0]  RCP_C     = RCP_W'(RCP);
	localparam logic [VAL_W-1:0]  SIZE_V    = VAL_W'(TABLE_SIZE);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_DIG - 1);

	logic [PAD_W-1:0]  key_sh_q;
	logic [IDX_W-1:0]  rem_q;
	logic [VAL_W-1:0]  val_q;
	logic [DIG_W-1:0]  quot_q;
	logic [STEP_W-1:0] step_q;
	logic              phase_q;
	logic              busy_q;
	logic              done_q;
	logic [VAL_W-1:0]  val;
	logic [PROD_W-1:0] prod;
	logic [VAL_W-1:0]  back;
	logic [VAL_W-1:0]  diff;

	// Append the next key byte to the partial remainder, estimate the quotient
	// by the scaled reciprocal, then subtract quotient times table size
	always_comb begin
		val  = {rem_q, key_sh_q[PAD_W-1 -: DIG_W]};
		prod = PROD_W'(val) * PROD_W'(RCP_C);
		back = VAL_W'(quot_q) * SIZE_V;
		diff = val_q - back;
	end

	// Control: two phases per key byte after start, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				step_q  <= '0;
				phase_q <= 1'b0;
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// Datapath: quotient estimate, partial remainder and key shifter
	always_ff @(posedge clk) begin
		if (start) begin
			key_sh_q <= PAD_W'(key);
			rem_q    <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				val_q  <= val;
				quot_q <= prod[SHIFT +: DIG_W];
			end else begin
				rem_q    <= diff[IDX_W-1:0];
				key_sh_q <= key_sh_q << DIG_W;
			end
		end
	end

	assign done = done_q;
	assign home = rem_q;

endmodule

// ----- rtl/linear_probe_hash_table_unit.sv -----
// Linear-probe hash table: insert or look up one key per item.
// The home slot comes from the modulo unit, which works through the key one byte at a time;
// probing then reads one slot per cycle from the home slot on, checking each read in the
// following cycle, and the result then waits until taken.
// One item at a time: no new item is accepted until the result has been taken.
// Reset: clears all TABLE_SIZE slots, one per cycle, accepting no item meanwhile.
module linear_probe_hash_table_unit #(
	parameter int unsigned TABLE_SIZE = 32,
	parameter int unsigned KEY_BITS   = 31
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((KEY_BITS+7)/8)*8-1:0]      s_tdata,   // [KEY_BITS-1:0] key, rest zero
	input  logic                               s_tuser,   // [0] func
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata    // [0] ok, [5:1] location
);
	import lpht_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
	localparam int unsigned CNT_W = $clog2(TABLE_SIZE + 1);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] ALL_SLOTS = CNT_W'(TABLE_SIZE);

	state_t state_q, state_d;

	// Slot storage: {valid, key}
	logic [KEY_BITS:0]   mem_q [TABLE_SIZE];
	logic [KEY_BITS:0]   rdata_s1;
	logic [IDX_W-1:0]    rd_addr_s1;
	logic                rd_vld_s1;

	logic                func_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IDX_W-1:0]    slot_q;
	logic [IDX_W-1:0]    slot_next;
	logic [CNT_W-1:0]    issued_q;
	logic                all_issued;

	logic                m_tvalid_q;
	logic                ok_q;
	logic [LOC_W-1:0]    loc_q;
	logic [31:0]         addr_ext;

	logic                hash_start;
	logic                hash_done;
	logic [IDX_W-1:0]    hash_home;

	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	logic [KEY_BITS:0]   mem_wd;
	logic                mem_re;
	logic                slot_hit;
	logic                probe_done;
	logic                probe_ok;

	lpht_hash #(
		.TABLE_SIZE (TABLE_SIZE),
		.KEY_BITS   (KEY_BITS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (s_tdata[KEY_BITS-1:0]),
		.done   (hash_done),
		.home   (hash_home)
	);

	assign slot_next  = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
	assign all_issued = (issued_q == ALL_SLOTS);

	// Slot match: insert wants a free slot, lookup wants a valid equal key
	always_comb begin
		if (func_q == FUNC_INSERT) begin
			slot_hit = !rdata_s1[KEY_BITS];
		end else begin
			slot_hit = rdata_s1[KEY_BITS] && (rdata_s1[KEY_BITS-1:0] == key_q);
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_wa     = slot_q;
		mem_wd     = '0;
		mem_re     = 1'b0;
		hash_start = 1'b0;
		probe_done = 1'b0;
		probe_ok   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (slot_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					hash_start = 1'b1;
					state_d    = ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (rd_vld_s1 && slot_hit) begin
					probe_done = 1'b1;
					probe_ok   = 1'b1;
					if (func_q == FUNC_INSERT) begin
						mem_we = 1'b1;
						mem_wa = rd_addr_s1;
						mem_wd = {1'b1, key_q};
					end
				end else if (all_issued) begin
					probe_done = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
				if (probe_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Slot memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_s1   <= mem_q[slot_q];
			rd_addr_s1 <= slot_q;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (hash_start) begin
			func_q <= s_tuser;
			key_q  <= s_tdata[KEY_BITS-1:0];
		end
	end

	// Advance the slot pointer through clearing and probing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			issued_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			if (hash_start) begin
				issued_q <= '0;
			end
			if (state_q == ST_CLEAR) begin
				slot_q <= slot_next;
			end else if (hash_done) begin
				slot_q <= hash_home;
			end else if (mem_re) begin
				slot_q   <= slot_next;
				issued_q <= issued_q + 1'b1;
			end
		end
	end

	assign addr_ext = 32'(rd_addr_s1);

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (probe_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (probe_done) begin
			ok_q  <= probe_ok;
			loc_q <= (probe_ok && func_q == FUNC_LOOKUP) ? addr_ext[LOC_W-1:0] : '0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, loc_q, ok_q};

	// Never accept an item while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("item accepted while a result is pending");

	// Read data only arrives during probing
	a_read_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_PROBE))
		else $error("slot read outside of probe");

	// Modulo unit finishes only while waiting for it
	a_hash_done: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> (state_q == ST_HASH))
		else $error("home slot ready outside of hash phase");

	// Probe never reads more slots than the table holds
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (issued_q <= ALL_SLOTS))
		else $error("probe ran past table size");

endmodule
